FILE: src/box_blur_3x3_rgb_defines.svh
// Assertion macros shared by the box blur RTL.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bb_pkg.sv
// Shared types and constants of the box blur block.
// No dependencies; all other files but the macros header import this package.
package bb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = DIM_W;
  localparam int CH_W        = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // Index 2 is red, 1 green, 0 blue.
  typedef logic [2:0][CH_W-1:0] bb_pixel_t;

  typedef struct packed {
    bb_pixel_t        pixel;
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             edge_col;
    logic             col0_en;
    logic             top_en;
    logic             bot_en;
    logic             frame_end;
  } bb_item_t;

  typedef struct packed {
    logic     valid;
    bb_item_t item;
  } bb_push_t;

endpackage

FILE: src/bb_if.sv
// Stream interfaces of the box blur block: pixel input and result output.
// Depends on bb_pkg for the channel width.
interface bb_in_if import bb_pkg::*;;
  logic            valid;
  logic            ready;
  logic            command;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  modport source (output valid, command, red, green, blue, input ready);
  modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface bb_out_if import bb_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

FILE: src/bb_front.sv
// Front end: configuration registers, raster position tracking and item classification.
// Depends on bb_pkg and the bb_in_if interface.
module bb_front import bb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  bb_in_if.sink                pix_in,
  input  logic                 q_full,
  output bb_push_t             push
);

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] MIN_D = DIM_W'(2);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [DIM_W:0]   h_plus1;
  logic [DIM_W-1:0] col_inc;
  logic             accept;
  logic             ignore;
  logic             edge_col;
  logic             emit;
  logic             done;
  logic             in_frame;

  assign w = (frame_width < MIN_D) ? MIN_D : (frame_width > MAX_W) ? MAX_W : frame_width;
  assign h = (frame_height < MIN_D) ? MIN_D : (frame_height > MAX_H) ? MAX_H : frame_height;
  assign h_plus1 = {1'b0, h} + (DIM_W+1)'(1);

  assign pix_in.ready = !q_full;
  assign accept   = pix_in.valid && pix_in.ready;
  assign in_frame = row < h;
  // A drain tick before the frame is complete carries no information.
  assign ignore   = pix_in.command && in_frame;
  assign edge_col = (col == '0);
  assign emit     = (row >= ROW_W'(2)) || (row == ROW_W'(1) && !edge_col);
  assign done     = emit && edge_col && ({1'b0, row} == h_plus1);
  assign col_inc  = {1'b0, col} + DIM_W'(1);

  always_comb begin
    push.valid          = accept && !ignore;
    push.item.pixel     = in_frame ? {pix_in.red, pix_in.green, pix_in.blue} : '0;
    push.item.addr      = col;
    push.item.emit      = emit;
    push.item.edge_col  = edge_col;
    push.item.col0_en   = edge_col || (col >= COL_W'(2));
    push.item.frame_end = done;
    if (edge_col) begin
      // Right-hand pixel of the line two above the current one.
      push.item.top_en = row > ROW_W'(2);
      push.item.bot_en = row <= h;
    end else begin
      push.item.top_en = row > ROW_W'(1);
      push.item.bot_en = row < h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width <= cfg_data;
          col         <= '0;
          row         <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height <= cfg_data;
          col          <= '0;
          row          <= '0;
        end
        default: ;
      endcase
    end else if (accept && !ignore) begin
      if (done) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= w) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

FILE: src/bb_fifo.sv
// Short queue of classified items between the front end and the back end.
// Depends on bb_pkg and the assertion macros header.
`include "box_blur_3x3_rgb_defines.svh"
module bb_fifo import bb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bb_push_t push,
  input  logic     pop,
  output bb_item_t head,
  output logic     empty,
  output logic     full
);

  bb_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)        rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push.valid && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push.valid) count <= count - (QPTR_W+1)'(1);
    end
  end

  `BB_ASSERT_IMP(a_no_overflow, push.valid, !full, "queue written while full")
  `BB_ASSERT_IMP(a_no_underflow, pop, !empty, "queue read while empty")
  `BB_ASSERT_NXT(a_count_up, push.valid && !pop, count == $past(count) + 1'b1, "queue count lost")

endmodule

FILE: src/bb_back.sv
// Back end: line stores, 3x3 window, channel sums and division by the neighbour count.
// Depends on bb_pkg and the bb_out_if interface.
module bb_back import bb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bb_item_t head,
  input  logic     empty,
  output logic     pop,
  bb_out_if.source pix_out
);

  localparam int SUM_W = 12;
  localparam logic [13:0] RECIP6 = 14'd10923;
  localparam logic [13:0] RECIP9 = 14'd7282;

  typedef enum logic [1:0] {DIV_BY_4, DIV_BY_6, DIV_BY_9} div_t;

  function automatic logic [CH_W-1:0] divide(input logic [SUM_W-1:0] s, input div_t d);
    logic [SUM_W+13:0] p;
    logic [CH_W-1:0]   q;
    p = '0;
    unique case (d)
      DIV_BY_4: q = s[CH_W+1:2];
      DIV_BY_6: begin
        p = s * RECIP6;
        q = p[23:16];
      end
      default: begin
        p = s * RECIP9;
        q = p[23:16];
      end
    endcase
    return q;
  endfunction

  bb_pixel_t line_upper  [MAX_WIDTH];
  bb_pixel_t line_middle [MAX_WIDTH];
  bb_pixel_t up_rd;
  bb_pixel_t mid_rd;

  logic      en;
  logic      s1_valid;
  bb_item_t  s1_item;
  bb_pixel_t win1 [3];
  bb_pixel_t win2 [3];
  bb_pixel_t newcol [3];
  logic [2:0][SUM_W-1:0] sums;
  div_t      div_sel;
  logic      row_en [3];

  logic                  s2_valid;
  logic [2:0][SUM_W-1:0] s2_sums;
  div_t                  s2_div;
  logic                  s2_frame_end;

  assign en  = !pix_out.valid || pix_out.ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (en) begin
      up_rd   <= line_upper[head.addr];
      mid_rd  <= line_middle[head.addr];
      s1_item <= head;
    end
    if (en && s1_valid) begin
      line_upper[s1_item.addr]  <= mid_rd;
      line_middle[s1_item.addr] <= s1_item.pixel;
    end
  end

  assign newcol[0] = up_rd;
  assign newcol[1] = mid_rd;
  assign newcol[2] = s1_item.pixel;
  assign row_en[0] = s1_item.top_en;
  assign row_en[1] = 1'b1;
  assign row_en[2] = s1_item.bot_en;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sums[ch] = '0;
      for (int k = 0; k < 3; k++) begin
        if (row_en[k]) begin
          sums[ch] = sums[ch] + SUM_W'(win2[k][ch])
                   + (s1_item.col0_en ? SUM_W'(win1[k][ch]) : SUM_W'(0))
                   + (!s1_item.edge_col ? SUM_W'(newcol[k][ch]) : SUM_W'(0));
        end
      end
    end
    if (s1_item.top_en && s1_item.bot_en && s1_item.col0_en && !s1_item.edge_col) begin
      div_sel = DIV_BY_9;
    end else if (!(s1_item.top_en && s1_item.bot_en)
                 && !(s1_item.col0_en && !s1_item.edge_col)) begin
      div_sel = DIV_BY_4;
    end else begin
      div_sel = DIV_BY_6;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= win2[k];
        win2[k] <= newcol[k];
      end
    end
    if (en) begin
      s2_sums           <= sums;
      s2_div            <= div_sel;
      s2_frame_end      <= s1_item.frame_end;
      pix_out.out_red   <= divide(s2_sums[2], s2_div);
      pix_out.out_green <= divide(s2_sums[1], s2_div);
      pix_out.out_blue  <= divide(s2_sums[0], s2_div);
      pix_out.frame_end <= s2_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      pix_out.valid <= 1'b0;
    end else if (en) begin
      s1_valid      <= pop;
      s2_valid      <= s1_valid && s1_item.emit;
      pix_out.valid <= s2_valid;
    end
  end

endmodule

FILE: src/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur.
// Depends on bb_pkg, bb_if, bb_front, bb_fifo and bb_back.
//
// Usage: pixels enter on pix_in in raster order, one transaction each, with
// command low; command high marks a drain tick. Results leave on pix_out as
// the truncated per-channel mean of the in-frame 3x3 neighbourhood (divisor
// 9, 6 or 4), frame_end marking the last pixel of the frame. A result is due
// once the item one line plus one pixel after its pixel has been accepted,
// so the final line plus one pixel are pushed out with drain ticks or the
// pixels of the next frame's stream. Drain ticks sent mid-frame are dropped.
// Throughput is one transaction per cycle on both channels unless pix_out
// stalls. A result reaches pix_out through the queue, ending with the
// line-store read, then the window sums register and the division into the
// output register.
// Writing frame_width (index 0) or frame_height (index 1) on the cfg port
// restarts the frame; write only while the block is idle.
// Reset restores 640 by 480, restarts the frame and empties the pipeline; the
// line stores keep their contents and need no clearing pass.
// When pix_out is stalled the back end holds still; the four-entry queue then
// fills and pix_in.ready falls until the receiver takes the waiting result.
module box_blur_3x3_rgb import bb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  bb_in_if.sink                pix_in,
  bb_out_if.source             pix_out
);

  bb_push_t push;
  bb_item_t head;
  logic     q_empty;
  logic     q_full;
  logic     q_pop;

  // Front end tracks the raster position and tags each item.
  bb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .q_full    (q_full),
    .push      (push)
  );

  // The queue lets the input keep flowing while the output stalls briefly.
  bb_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (q_pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back end owns the line stores and the arithmetic.
  bb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (q_empty),
    .pop     (q_pop),
    .pix_out (pix_out)
  );

endmodule

FILE: tb/tb_box_blur_3x3_rgb.sv
// Self-checking testbench of the 3x3 RGB box blur: a scoreboard class that
// predicts every blurred pixel, plus tasks that drive the stream and cfg ports.
// Depends on bb_pkg, the bb_in_if / bb_out_if interfaces and box_blur_3x3_rgb.
`timescale 1ns / 100ps

module tb_box_blur_3x3_rgb;
  import bb_pkg::*;

  // Predicts the blurred output stream and checks what the block delivers.
  class blur_scoreboard;
    typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
    } blurred_t;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    bb_pixel_t        upper_line[MAX_WIDTH];
    bb_pixel_t        middle_line[MAX_WIDTH];
    bb_pixel_t        win[3][3];
    int unsigned      next_col;
    int unsigned      next_row;
    int unsigned      done_count;
    blurred_t         blurred_q[$];
    int               errors;

    function new();
      width_reg  = 11'd640;
      height_reg = 11'd480;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] = '0;
        end
      end
      next_col   = 0;
      next_row   = 0;
      done_count = 0;
      errors     = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return v;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
        if (idx == CFG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        next_col   = 0;
        next_row   = 0;
        done_count = 0;
      end
    endfunction

    // Truncated mean over window rows r0..r2 and columns c0..c1.
    function blurred_t window_mean(int r0, int r2, int c0, int c1);
      blurred_t    res;
      int unsigned sr, sg, sb, n;
      sr = 0; sg = 0; sb = 0; n = 0;
      for (int i = r0; i <= r2; i++) begin
        for (int j = c0; j <= c1; j++) begin
          sr += win[i][j][2];
          sg += win[i][j][1];
          sb += win[i][j][0];
          n++;
        end
      end
      res.red       = CH_W'(sr / n);
      res.green     = CH_W'(sg / n);
      res.blue      = CH_W'(sb / n);
      res.frame_end = 1'b0;
      return res;
    endfunction

    // Advances the prediction by one accepted input transaction.
    function void note_input(logic drain, logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                             logic [CH_W-1:0] blue);
      int unsigned w, h, c, r, orow;
      bb_pixel_t   data, up, mid;
      bit          emit;
      blurred_t    res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      c = next_col;
      r = next_row;
      if (c >= w) c = 0;
      // Drain ticks inside the frame are dropped; pixels past its end act as drains.
      if (drain && r < h) return;
      data = '0;
      if (!drain && r < h) data = {red, green, blue};
      emit = (r >= 2) || (r == 1 && c >= 1);
      // The right-edge pixel of line r-2 comes from the window before it shifts.
      if (emit && c == 0) begin
        orow = r - 2;
        res = window_mean(orow > 0 ? 0 : 1, orow + 1 < h ? 2 : 1, 1, 2);
      end
      up  = upper_line[c];
      mid = middle_line[c];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = data;
      upper_line[c]  = mid;
      middle_line[c] = data;
      if (emit && c != 0) begin
        orow = r - 1;
        res = window_mean(orow > 0 ? 0 : 1, orow + 1 < h ? 2 : 1, c >= 2 ? 0 : 1, 2);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      next_col = c;
      next_row = r;
      if (!emit) return;
      res.frame_end = (done_count + 1 >= w * h);
      if (res.frame_end) begin
        next_col   = 0;
        next_row   = 0;
        done_count = 0;
      end else begin
        done_count = (done_count + 1) & 20'hFFFFF;
      end
      blurred_q.push_back(res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CH_W-1:0] red, logic [CH_W-1:0] green, logic [CH_W-1:0] blue,
                      logic frame_end);
      blurred_t exp_px;
      if (blurred_q.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d/%0d fe=%0b", red, green, blue, frame_end));
        return;
      end
      exp_px = blurred_q.pop_front();
      if (red !== exp_px.red)
        report($sformatf("out_red %0d, expected %0d", red, exp_px.red));
      if (green !== exp_px.green)
        report($sformatf("out_green %0d, expected %0d", green, exp_px.green));
      if (blue !== exp_px.blue)
        report($sformatf("out_blue %0d, expected %0d", blue, exp_px.blue));
      if (frame_end !== exp_px.frame_end)
        report($sformatf("frame_end %0b, expected %0b", frame_end, exp_px.frame_end));
    endtask

    function int pending();
      return blurred_q.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1_000_000;
  // Pipeline depth plus the queue, with some margin, for the quiet periods.
  localparam int SETTLE_CYCLES = 16;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  bb_in_if  pix_in ();
  bb_out_if pix_out ();

  box_blur_3x3_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in.sink),
    .pix_out   (pix_out.source)
  );

  blur_scoreboard blur_sb;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Cycles the receiver is asked to hold off; the receiver counts them down.
  int unsigned hold_off_req;
  int unsigned item_count;
  longint unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle counter and watchdog: a hung block ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_box_blur_3x3_rgb: errors");
        $finish;
      end
    end
  end

  // Receiver: checks each accepted result transaction, then decides whether
  // to take the next one. A requested hold-off keeps ready low throughout so
  // that the internal queue fills and pix_in.ready has to fall.
  initial begin
    pix_out.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (pix_out.valid && pix_out.ready)
        blur_sb.check_result(pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                             pix_out.frame_end);
      if (hold_off_req > 0) begin
        hold_off_req--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
    end
  end

  // Biased channel value: the extremes turn up far more often than by chance.
  function automatic logic [CH_W-1:0] rand_channel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  // Offers one input transaction and returns on the edge that accepts it.
  task automatic send_item(logic drain, logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                           logic [CH_W-1:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid   <= 1'b0;
      pix_in.command <= 1'($urandom_range(1));
      pix_in.red     <= CH_W'($urandom_range(255));
      @(posedge clk);
    end
    pix_in.valid   <= 1'b1;
    pix_in.command <= drain;
    pix_in.red     <= red;
    pix_in.green   <= green;
    pix_in.blue    <= blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    blur_sb.note_input(drain, red, green, blue);
    item_count++;
  endtask

  task automatic send_pixel();
    send_item(1'b0, rand_channel(), rand_channel(), rand_channel());
  endtask

  task automatic send_drain();
    send_item(1'b1, rand_channel(), rand_channel(), rand_channel());
  endtask

  // Waits until every predicted result has arrived and the pipeline is quiet.
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (blur_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blur_sb.configure(idx, val);
  endtask

  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // A whole frame of w by h pixels followed by the w+1 drains that flush it.
  task automatic send_frame(int unsigned w, int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) send_pixel();
    for (int unsigned i = 0; i <= w; i++) send_drain();
  endtask

  // One random phase. Mostly well-formed frames with random content; some
  // frames run straight into the next one, which flushes them instead of
  // drains; stray drains mid-frame and truncated frames make up the noise.
  task automatic random_phase(int unsigned send_pct, int unsigned recv_pct,
                              int unsigned quota);
    int unsigned w, h, start, n;
    logic [DIM_W-1:0] wreg, hreg;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = item_count;
    while (item_count - start < quota) begin
      wreg = DIM_W'($urandom_range(2, 7));
      hreg = DIM_W'($urandom_range(2, 5));
      if ($urandom_range(9) == 0) wreg = DIM_W'($urandom_range(1));
      if ($urandom_range(9) == 0) hreg = DIM_W'($urandom_range(1));
      set_frame(wreg, hreg);
      w = (wreg < 2) ? 2 : wreg;
      h = (hreg < 2) ? 2 : hreg;
      repeat ($urandom_range(1, 4)) begin
        n = w * h;
        // A truncated frame, abandoned by the reconfiguration that follows.
        if ($urandom_range(9) == 0) n = $urandom_range(1, n - 1);
        for (int unsigned i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0) send_drain();
          send_pixel();
        end
        if (n < w * h) break;
        // Otherwise flush with drains or with the following frame's pixels.
        if ($urandom_range(2) == 0)
          for (int unsigned i = 0; i <= w; i++) send_drain();
      end
      // Flush whatever frame is still open before the next reconfiguration.
      for (int unsigned i = 0; i <= w; i++) send_drain();
    end
  endtask

  initial begin
    blur_sb        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 0;
    item_count     = 0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pix_in.valid   = 1'b0;
    pix_in.command = 1'b0;
    pix_in.red     = '0;
    pix_in.green   = '0;
    pix_in.blue    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Indexes beyond the two registers must be ignored.
    write_reg(2'd2, 11'h7FF);
    write_reg(2'd3, 11'h555);

    // Smallest frame, reached through registers below range: a drain in the
    // middle of the frame is dropped; the pixels carry extreme channel values.
    set_frame(11'd0, 11'd1);
    send_item(1'b0, 8'hFF, 8'h00, 8'hFF);
    send_item(1'b1, 8'h12, 8'h34, 8'h56);
    send_item(1'b0, 8'h00, 8'hFF, 8'hFF);
    send_item(1'b0, 8'hFF, 8'hFF, 8'h00);
    send_item(1'b0, 8'h00, 8'h00, 8'h00);
    repeat (3) send_drain();
    // A drain at the start of the new frame produces nothing.
    send_drain();

    // A 3 by 3 frame: every divisor. Its last line is flushed by pixels sent
    // past the end of the frame, which count as drains.
    set_frame(11'd3, 11'd3);
    repeat (9) send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(1'b0, 8'hAA, 8'h55, 8'h0F);

    // Registers above range clamp to the widest line: one full line and two
    // pixels of the next give the first result; the rest of the frame is
    // abandoned by the reconfiguration that follows.
    set_frame(11'h7FF, 11'h7FF);
    repeat (MAX_WIDTH + 2) send_pixel();

    // Long hold-off while the sender keeps offering: the queue fills.
    set_frame(11'd4, 11'd3);
    hold_off_req = 300;
    send_frame(4, 3);

    random_phase(0, 0, 50);
    random_phase(80, 0, 50);
    random_phase(0, 80, 50);
    random_phase(30, 30, 50);

    wait_idle();
    if (blur_sb.errors == 0) begin
      $display("tb_box_blur_3x3_rgb: clean");
    end else begin
      $display("tb_box_blur_3x3_rgb: errors");
    end
    $finish;
  end

endmodule
